// ===== design/bpc_pkg.sv =====
// shared types, constants and arithmetic helpers for the pressure compensation block
package bpc_pkg;

   localparam int OversamplingShift = 3;
   localparam int DivSteps = 32;

   // floor(x / 100) == (x * RecipHundred) >> RecipShift for any 32-bit unsigned x
   localparam logic [31:0] RecipHundred = 32'h51EB_851F;
   localparam int RecipShift = 37;

   localparam logic [2:0] RegAc1Ac2 = 3'd0;
   localparam logic [2:0] RegAc3Ac4 = 3'd1;
   localparam logic [2:0] RegAc5Ac6 = 3'd2;
   localparam logic [2:0] RegB1B2   = 3'd3;
   localparam logic [2:0] RegMcMd   = 3'd4;

   // sign handling around an unsigned divider
   typedef struct packed {
      logic [31:0] num;
      logic [31:0] den;
      logic        neg;
   } div_req_type;

   // truncating signed divide by a power of two
   function automatic logic [31:0] sdiv_pow2(input logic [31:0] a, input int unsigned sh);
      logic [31:0] bias;
      bias = (32'd1 << sh) - 32'd1;
      if (a[31]) begin
         sdiv_pow2 = 32'($signed(a + bias) >>> sh);
      end else begin
         sdiv_pow2 = 32'($signed(a) >>> sh);
      end
   endfunction

   function automatic logic [31:0] abs32(input logic [31:0] a);
      abs32 = a[31] ? (32'd0 - a) : a;
   endfunction

endpackage

// ===== design/bpc_udiv.sv =====
// pipelined 32-bit unsigned divider, one quotient bit per stage, with sign fixup
module bpc_udiv (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  bpc_pkg::div_req_type in_req,
   input  logic [95:0]          in_side,
   output logic                 out_valid,
   output logic [31:0]          out_quot,
   output logic [95:0]          out_side
);
   import bpc_pkg::*;

   logic [31:0] rem_ff [DivSteps];
   logic [31:0] quo_ff [DivSteps];
   logic [31:0] den_ff [DivSteps];
   logic        neg_ff [DivSteps];
   logic [95:0] side_ff [DivSteps];
   logic        vld_ff [DivSteps];

   for (genvar i = 0; i < DivSteps; i++) begin : g_step
      logic [31:0] rem_cur, quo_cur, den_cur;
      logic        neg_cur, vld_cur;
      logic [95:0] side_cur;
      logic [32:0] trial;
      logic [32:0] shifted;
      if (i == 0) begin : g_first
         assign rem_cur  = 32'd0;
         assign quo_cur  = in_req.num;
         assign den_cur  = in_req.den;
         assign neg_cur  = in_req.neg;
         assign side_cur = in_side;
         assign vld_cur  = in_valid;
      end else begin : g_next
         assign rem_cur  = rem_ff[i-1];
         assign quo_cur  = quo_ff[i-1];
         assign den_cur  = den_ff[i-1];
         assign neg_cur  = neg_ff[i-1];
         assign side_cur = side_ff[i-1];
         assign vld_cur  = vld_ff[i-1];
      end
      always_comb begin
         shifted = {rem_cur, quo_cur[31]};
         trial   = shifted - {1'b0, den_cur};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_cur;
         end
         if (trial[32]) begin
            rem_ff[i] <= shifted[31:0];
            quo_ff[i] <= {quo_cur[30:0], 1'b0};
         end else begin
            rem_ff[i] <= trial[31:0];
            quo_ff[i] <= {quo_cur[30:0], 1'b1};
         end
         den_ff[i]  <= den_cur;
         neg_ff[i]  <= neg_cur;
         side_ff[i] <= side_cur;
      end
   end

   assign out_valid = vld_ff[DivSteps-1];
   assign out_quot  = neg_ff[DivSteps-1] ? (32'd0 - quo_ff[DivSteps-1]) : quo_ff[DivSteps-1];
   assign out_side  = side_ff[DivSteps-1];
endmodule

// ===== design/baro_pressure_temp_compensation.sv =====
// top level of the barometric temperature and pressure compensation pipeline
// order: stages a and b, divider 1, stages c to g, divider 2, stages h to k, output register
// throughput: one transaction per cycle; busy is never raised, the two dividers are pipelined
// each divider is 32 one-bit stages, which sets most of the latency
// reset clears calibration registers to zero and empties the pipeline
// results are strobed for one cycle and cannot be stalled by the receiver
module baro_pressure_temp_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_raw_temperature,
   input  logic [18:0] req_raw_pressure,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output logic        rsp_valid,
   output logic signed [15:0] rsp_temperature_out,
   output logic [19:0] rsp_pressure_out,
   output logic        rsp_status
);
   import bpc_pkg::*;

   logic [31:0] ac1ac2_ff, ac3ac4_ff, ac5ac6_ff, b1b2_ff, mcmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ac1ac2_ff <= '0;
         ac3ac4_ff <= '0;
         ac5ac6_ff <= '0;
         b1b2_ff   <= '0;
         mcmd_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            RegAc1Ac2: ac1ac2_ff <= csr_data;
            RegAc3Ac4: ac3ac4_ff <= csr_data;
            RegAc5Ac6: ac5ac6_ff <= csr_data;
            RegB1B2:   b1b2_ff   <= csr_data;
            RegMcMd:   mcmd_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = {{16{ac1ac2_ff[31]}}, ac1ac2_ff[31:16]};
   assign ac2 = {{16{ac1ac2_ff[15]}}, ac1ac2_ff[15:0]};
   assign ac3 = {{16{ac3ac4_ff[31]}}, ac3ac4_ff[31:16]};
   assign ac4 = {16'd0, ac3ac4_ff[15:0]};
   assign ac5 = {16'd0, ac5ac6_ff[31:16]};
   assign ac6 = {16'd0, ac5ac6_ff[15:0]};
   assign b1  = {{16{b1b2_ff[31]}}, b1b2_ff[31:16]};
   assign b2  = {{16{b1b2_ff[15]}}, b1b2_ff[15:0]};
   assign mc  = {{16{mcmd_ff[31]}}, mcmd_ff[31:16]};
   assign md  = {{16{mcmd_ff[15]}}, mcmd_ff[15:0]};

   logic accept;
   assign accept = start & ~busy;

   // stage a: ut-ac6 times ac5
   logic        a_v_ff;
   logic [31:0] a_prod_ff;
   logic [18:0] a_up_ff;
   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else       a_v_ff <= accept;
      a_prod_ff <= ({16'd0, req_raw_temperature} - ac6) * ac5;
      a_up_ff   <= req_raw_pressure;
   end

   // stage b: x1 and divisor x1+md
   logic        b_v_ff;
   logic [31:0] b_x1_ff, b_d_ff, b_mc_ff;
   logic [18:0] b_up_ff;
   logic [31:0] x1_t;
   assign x1_t = sdiv_pow2(a_prod_ff, 15);
   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else       b_v_ff <= a_v_ff;
      b_x1_ff <= x1_t;
      b_d_ff  <= x1_t + md;
      b_mc_ff <= mc << 11;
      b_up_ff <= a_up_ff;
   end

   // divider 1: mc*2048 / d
   div_req_type d1_req;
   logic        d1_v;
   logic [31:0] d1_q;
   logic [95:0] d1_side;
   assign d1_req = '{num: abs32(b_mc_ff), den: abs32(b_d_ff),
                     neg: b_mc_ff[31] ^ b_d_ff[31]};
   bpc_udiv u_div_t (
      .clock(clock), .reset(reset), .in_valid(b_v_ff), .in_req(d1_req),
      .in_side({b_x1_ff, 12'd0, (b_d_ff == 32'd0), b_up_ff, 32'd0}),
      .out_valid(d1_v), .out_quot(d1_q), .out_side(d1_side)
   );

   // stage c: b5, t, b6
   logic        c_v_ff, c_err_ff;
   logic [31:0] c_b6_ff, c_t_ff;
   logic [18:0] c_up_ff;
   logic [31:0] b5_t, b5p8;
   assign b5_t = d1_side[95:64] + d1_q;
   assign b5p8 = b5_t + 32'd8;
   always_ff @(posedge clock) begin
      if (reset) c_v_ff <= 1'b0;
      else       c_v_ff <= d1_v;
      c_err_ff <= d1_side[51];
      c_up_ff  <= d1_side[50:32];
      c_t_ff   <= 32'($signed(b5p8) >>> 4);
      c_b6_ff  <= b5_t - 32'd4000;
   end

   // stage d: products of b6
   logic        d_v_ff, d_err_ff;
   logic [31:0] d_sqp_ff, d_ac2b6_ff, d_ac3b6_ff, d_b6_ff, d_t_ff;
   logic [18:0] d_up_ff;
   always_ff @(posedge clock) begin
      if (reset) d_v_ff <= 1'b0;
      else       d_v_ff <= c_v_ff;
      d_sqp_ff   <= c_b6_ff * c_b6_ff;
      d_ac2b6_ff <= ac2 * c_b6_ff;
      d_ac3b6_ff <= ac3 * c_b6_ff;
      d_b6_ff    <= c_b6_ff;
      d_t_ff     <= c_t_ff;
      d_err_ff   <= c_err_ff;
      d_up_ff    <= c_up_ff;
   end

   // stage e: sq and its products
   logic        e_v_ff, e_err_ff;
   logic [31:0] e_b2sq_ff, e_b1sq_ff, e_x2a_ff, e_x1c_ff, e_t_ff;
   logic [18:0] e_up_ff;
   logic [31:0] sq_t;
   assign sq_t = sdiv_pow2(d_sqp_ff, 12);
   always_ff @(posedge clock) begin
      if (reset) e_v_ff <= 1'b0;
      else       e_v_ff <= d_v_ff;
      e_b2sq_ff <= b2 * sq_t;
      e_b1sq_ff <= b1 * sq_t;
      e_x2a_ff  <= sdiv_pow2(d_ac2b6_ff, 11);
      e_x1c_ff  <= sdiv_pow2(d_ac3b6_ff, 13);
      e_t_ff    <= d_t_ff;
      e_err_ff  <= d_err_ff;
      e_up_ff   <= d_up_ff;
   end

   // stage f: b3 and x3 for b4
   logic        f_v_ff, f_err_ff;
   logic [31:0] f_b3_ff, f_x3_ff, f_t_ff;
   logic [18:0] f_up_ff;
   logic [31:0] x3a, b3s, x3b;
   assign x3a = sdiv_pow2(e_b2sq_ff, 11) + e_x2a_ff;
   assign b3s = ((((ac1 << 2) + x3a) << OversamplingShift) + 32'd2);
   assign x3b = e_x1c_ff + sdiv_pow2(e_b1sq_ff, 16) + 32'd2;
   always_ff @(posedge clock) begin
      if (reset) f_v_ff <= 1'b0;
      else       f_v_ff <= e_v_ff;
      f_b3_ff  <= sdiv_pow2(b3s, 2);
      f_x3_ff  <= sdiv_pow2(x3b, 2) + 32'd32768;
      f_t_ff   <= e_t_ff;
      f_err_ff <= e_err_ff;
      f_up_ff  <= e_up_ff;
   end

   // stage g: b4 and b7
   logic        g_v_ff, g_err_ff;
   logic [31:0] g_b4_ff, g_b7_ff, g_t_ff;
   logic [31:0] b4_prod;
   // the product wraps at 32 bits before the shift
   assign b4_prod = f_x3_ff * ac4;
   always_ff @(posedge clock) begin
      if (reset) g_v_ff <= 1'b0;
      else       g_v_ff <= f_v_ff;
      g_b4_ff  <= b4_prod >> 15;
      g_b7_ff  <= ({13'd0, f_up_ff} - f_b3_ff) * 32'(50000 >> OversamplingShift);
      g_t_ff   <= f_t_ff;
      g_err_ff <= f_err_ff;
   end

   // divider 2: pressure quotient, unsigned
   div_req_type d2_req;
   logic        d2_v, g_big;
   logic [31:0] d2_q;
   logic [95:0] d2_side;
   assign g_big  = g_b7_ff[31];
   assign d2_req = '{num: g_big ? g_b7_ff : (g_b7_ff << 1), den: g_b4_ff, neg: 1'b0};
   bpc_udiv u_div_p (
      .clock(clock), .reset(reset), .in_valid(g_v_ff), .in_req(d2_req),
      .in_side({g_t_ff, 30'd0, g_big, g_err_ff | (g_b4_ff == 32'd0), 32'd0}),
      .out_valid(d2_v), .out_quot(d2_q), .out_side(d2_side)
   );

   // stage h: p and its products
   logic        h_v_ff, h_err_ff;
   logic [31:0] h_p_ff, h_t_ff, h_sq_ff, h_x2p_ff;
   logic [31:0] p_t, ps;
   assign p_t = d2_side[33] ? (d2_q << 1) : d2_q;
   assign ps  = sdiv_pow2(p_t, 8);
   always_ff @(posedge clock) begin
      if (reset) h_v_ff <= 1'b0;
      else       h_v_ff <= d2_v;
      h_p_ff   <= p_t;
      h_sq_ff  <= ps * ps;
      h_x2p_ff <= 32'hFFFF_E343 * p_t;
      h_t_ff   <= d2_side[95:64];
      h_err_ff <= d2_side[32];
   end

   // stage i: 3038 product
   logic        i_v_ff, i_err_ff;
   logic [31:0] i_m_ff, i_p_ff, i_t_ff, i_x2_ff;
   always_ff @(posedge clock) begin
      if (reset) i_v_ff <= 1'b0;
      else       i_v_ff <= h_v_ff;
      i_m_ff   <= h_sq_ff * 32'd3038;
      i_x2_ff  <= sdiv_pow2(h_x2p_ff, 16);
      i_p_ff   <= h_p_ff;
      i_t_ff   <= h_t_ff;
      i_err_ff <= h_err_ff;
   end

   // stage j: corrected p times 75
   logic        j_v_ff, j_err_ff;
   logic [31:0] j_p75_ff, j_t_ff, corr, pc;
   assign corr = sdiv_pow2(i_m_ff, 16) + i_x2_ff + 32'd3791;
   assign pc   = i_p_ff + sdiv_pow2(corr, 4);
   always_ff @(posedge clock) begin
      if (reset) j_v_ff <= 1'b0;
      else       j_v_ff <= i_v_ff;
      j_p75_ff <= pc * 32'd75;
      j_t_ff   <= i_t_ff;
      j_err_ff <= i_err_ff;
   end

   // stage k: signed /100 as a reciprocal multiply on the magnitude
   logic        k_v_ff, k_err_ff, k_neg_ff;
   logic [63:0] k_prod_ff;
   logic [31:0] k_t_ff;
   always_ff @(posedge clock) begin
      if (reset) k_v_ff <= 1'b0;
      else       k_v_ff <= j_v_ff;
      k_prod_ff <= {32'd0, abs32(j_p75_ff)} * {32'd0, RecipHundred};
      k_neg_ff  <= j_p75_ff[31];
      k_t_ff    <= j_t_ff;
      k_err_ff  <= j_err_ff;
   end

   logic [31:0] quot100, pq;
   assign quot100 = 32'(k_prod_ff >> RecipShift);
   assign pq      = k_neg_ff ? (32'd0 - quot100) : quot100;

   // output register with saturation
   logic [31:0] tf;
   assign tf = k_t_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= k_v_ff;
      end
      rsp_status <= k_err_ff;
      if (k_err_ff) begin
         rsp_temperature_out <= '0;
         rsp_pressure_out    <= '0;
      end else begin
         priority if ($signed(tf) > 32'sd32767) rsp_temperature_out <= 16'sh7FFF;
         else if ($signed(tf) < -32'sd32768)     rsp_temperature_out <= 16'sh8000;
         else                                     rsp_temperature_out <= tf[15:0];
         priority if (pq[31])                     rsp_pressure_out <= '0;
         else if (pq > 32'd1048575)                rsp_pressure_out <= 20'hFFFFF;
         else                                     rsp_pressure_out <= pq[19:0];
      end
   end
endmodule

// ===== tb/tb.sv =====
// testbench for the barometric temperature and pressure compensation block
`timescale 1ns / 1ps

module tb;
   import bpc_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [15:0] req_raw_temperature;
   logic [18:0] req_raw_pressure;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;
   logic        rsp_valid;
   logic signed [15:0] rsp_temperature_out;
   logic [19:0] rsp_pressure_out;
   logic        rsp_status;

   typedef struct packed {
      logic [15:0] temperature;
      logic [19:0] pressure;
      logic        status;
   } reading_type;

   localparam int DrainCycles = 200;
   localparam int WatchdogLimit = 5000;

   reading_type expected_readings[$];
   logic [31:0] cal_regs[5];
   int          fail_count;
   int          idle_cycles;
   bit          quiet_mode;

   baro_pressure_temp_compensation u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_raw_temperature(req_raw_temperature), .req_raw_pressure(req_raw_pressure),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_temperature_out(rsp_temperature_out),
      .rsp_pressure_out(rsp_pressure_out), .rsp_status(rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // truncating signed divide, min / -1 wraps
   function automatic logic signed [31:0] tdiv(logic signed [31:0] a, logic signed [31:0] b);
      logic [31:0] ua;
      logic [31:0] ub;
      logic [31:0] q;
      ua = a[31] ? 32'd0 - a : a;
      ub = b[31] ? 32'd0 - b : b;
      q = ua / ub;
      if (a[31] != b[31]) q = 32'd0 - q;
      return q;
   endfunction

   function automatic reading_type compensate(logic [15:0] ut_raw, logic [18:0] up_raw);
      logic signed [31:0] ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut;
      logic signed [31:0] x1, x2, x3, d, b3, b5, b6, sq, t, p;
      logic [31:0] ac4, b4, b7, pu, up;
      reading_type r;
      ac1 = 32'(signed'(cal_regs[RegAc1Ac2][31:16]));
      ac2 = 32'(signed'(cal_regs[RegAc1Ac2][15:0]));
      ac3 = 32'(signed'(cal_regs[RegAc3Ac4][31:16]));
      ac4 = {16'd0, cal_regs[RegAc3Ac4][15:0]};
      ac5 = {16'd0, cal_regs[RegAc5Ac6][31:16]};
      ac6 = {16'd0, cal_regs[RegAc5Ac6][15:0]};
      b1 = 32'(signed'(cal_regs[RegB1B2][31:16]));
      b2 = 32'(signed'(cal_regs[RegB1B2][15:0]));
      mc = 32'(signed'(cal_regs[RegMcMd][31:16]));
      md = 32'(signed'(cal_regs[RegMcMd][15:0]));
      ut = {16'd0, ut_raw};
      up = {13'd0, up_raw};
      r = '0;
      r.status = 1'b1;
      x1 = tdiv((ut - ac6) * ac5, 32768);
      d = x1 + md;
      if (d == 0) return r;
      x2 = tdiv(mc * 2048, d);
      b5 = x1 + x2;
      t = (b5 + 8) >>> 4;
      b6 = b5 - 4000;
      sq = tdiv(b6 * b6, 4096);
      x1 = tdiv(b2 * sq, 2048);
      x2 = tdiv(ac2 * b6, 2048);
      x3 = x1 + x2;
      b3 = tdiv(((ac1 * 4 + x3) << OversamplingShift) + 2, 4);
      x1 = tdiv(ac3 * b6, 8192);
      x2 = tdiv(b1 * sq, 65536);
      x3 = tdiv(x1 + x2 + 2, 4);
      b4 = (ac4 * (x3 + 32'd32768)) >> 15;
      if (b4 == 0) return r;
      b7 = (up - b3) * (32'd50000 >> OversamplingShift);
      if (!b7[31]) pu = (b7 * 2) / b4;
      else pu = (b7 / b4) * 2;
      p = pu;
      x1 = tdiv(p, 256);
      x1 = x1 * x1;
      x1 = tdiv(x1 * 3038, 65536);
      x2 = tdiv(-32'sd7357 * p, 65536);
      p = p + tdiv(x1 + x2 + 3791, 16);
      p = tdiv(p * 75, 100);
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      if (p < 0) p = 0;
      if (p > 1048575) p = 1048575;
      r.temperature = t[15:0];
      r.pressure = p[19:0];
      r.status = 1'b0;
      return r;
   endfunction

   // result checker and watchdog
   always @(posedge clock) begin
      reading_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_readings.size() == 0) begin
               $error("unexpected transaction: temp %0d press %0d status %0d",
                      rsp_temperature_out, rsp_pressure_out, rsp_status);
               fail_count++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_temperature_out !== want.temperature) begin
                  $error("temperature_out expected %0d actual %0d",
                         $signed(want.temperature), rsp_temperature_out);
                  fail_count++;
               end
               if (rsp_pressure_out !== want.pressure) begin
                  $error("pressure_out expected %0d actual %0d",
                         want.pressure, rsp_pressure_out);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WatchdogLimit) begin
            $display("baro_pressure_temp_compensation verification failed");
            $finish;
         end
      end
   end

   // start stays high into the next transaction; wait_drained drops it
   task automatic send_reading(logic [15:0] ut, logic [18:0] up);
      while (!quiet_mode && $urandom_range(99) < 17) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_raw_temperature <= ut;
      req_raw_pressure <= up;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_readings.push_back(compensate(ut, up));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_readings.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_cal(logic [2:0] idx, logic [31:0] value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
      if (idx <= RegMcMd) cal_regs[idx] = value;
   endtask

   task automatic load_cal(logic [31:0] r0, r1, r2, r3, r4);
      write_cal(RegAc1Ac2, r0);
      write_cal(RegAc3Ac4, r1);
      write_cal(RegAc5Ac6, r2);
      write_cal(RegB1B2, r3);
      write_cal(RegMcMd, r4);
   endtask

   task automatic test_reset_calibration();
      // all-zero coefficients: B4 is zero
      send_reading(16'd27898, 19'd23843);
      send_reading(16'hffff, 19'h7ffff);
      wait_drained();
   endtask

   task automatic test_datasheet_values();
      load_cal({16'd408, 16'hffb8}, {16'hf1d5, 16'd32741}, {16'd32757, 16'd23153},
               {16'd6190, 16'd4}, {16'h8000, 16'd2868});
      send_reading(16'd27898, 19'd23843 << 3);
      send_reading(16'd0, 19'd0);
      send_reading(16'hffff, 19'h7ffff);
      send_reading(16'h0000, 19'h7ffff);
      send_reading(16'hffff, 19'd0);
      send_reading(16'd23153, 19'd190000);
      wait_drained();
   endtask

   task automatic test_zero_divisor();
      // X1 + MD is zero when UT equals AC6 and MD is zero
      load_cal($urandom, {16'($urandom_range(65535)), 16'd32741}, {16'd32757, 16'd1000},
               $urandom, {16'd100, 16'd0});
      send_reading(16'd1000, 19'($urandom));
      send_reading(16'd1001, 19'($urandom));
      wait_drained();
      // AC4 zero forces B4 zero
      write_cal(RegAc3Ac4, {16'h1234, 16'd0});
      send_reading(16'd5000, 19'd100000);
      wait_drained();
   endtask

   task automatic test_extremes();
      // saturation and wrap corners
      load_cal(32'h7fff_8000, 32'h8000_ffff, 32'hffff_ffff, 32'h7fff_8000, 32'h8000_7fff);
      send_reading(16'd0, 19'd0);
      send_reading(16'hffff, 19'h7ffff);
      wait_drained();
      load_cal(32'h8000_7fff, 32'h7fff_0001, 32'h0001_0000, 32'h8000_7fff, 32'h7fff_8000);
      send_reading(16'd0, 19'h7ffff);
      send_reading(16'hffff, 19'd1);
      wait_drained();
      // unknown index leaves registers unchanged
      write_cal(3'd5, 32'hdead_beef);
      write_cal(3'd7, 32'h0);
      send_reading(16'h5555, 19'h2aaaa);
      send_reading(16'haaaa, 19'h55555);
      wait_drained();
   endtask

   task automatic test_random(int phases, int items_per_phase);
      for (int ph = 0; ph < phases; ph++) begin
         if (ph % 3 == 0) begin
            load_cal($urandom, $urandom, $urandom, $urandom, $urandom);
         end else begin
            // near-realistic coefficients with random jitter
            load_cal({16'(408 + $urandom_range(200) - 100), 16'(-72 + $urandom_range(40))},
                     {16'(-14891 + $urandom_range(400)), 16'(32741 + $urandom_range(400))},
                     {16'(32757 - $urandom_range(400)), 16'(23153 + $urandom_range(400))},
                     {16'(6190 + $urandom_range(200)), 16'($urandom_range(8))},
                     {16'(-8711 + $urandom_range(200)), 16'(2868 + $urandom_range(200))});
         end
         quiet_mode = (ph == phases / 2);
         for (int i = 0; i < items_per_phase; i++) begin
            if ($urandom_range(3) == 0) send_reading(16'($urandom), 19'($urandom));
            else send_reading(16'(20000 + $urandom_range(16000)),
                              19'(120000 + $urandom_range(200000)));
         end
         quiet_mode = 1'b0;
         wait_drained();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_raw_temperature = '0;
      req_raw_pressure = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      fail_count = 0;
      idle_cycles = 0;
      quiet_mode = 1'b0;
      for (int i = 0; i < 5; i++) cal_regs[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_calibration();
      test_datasheet_values();
      test_zero_divisor();
      test_extremes();
      test_random(10, 113);
      if (fail_count == 0) $display("baro_pressure_temp_compensation verification clean");
      else $display("baro_pressure_temp_compensation verification failed");
      $finish;
   end

endmodule
